[sv/bts_pkg.sv]
// Shared types, constants and helper functions of the BM25 top-k scorer.
package bts_pkg;

  localparam int unsigned MaxKeepDef = 16;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  localparam int unsigned DocW   = 31;
  localparam int unsigned TfW    = 16;
  localparam int unsigned DfW    = 24;
  localparam int unsigned DlW    = 20;
  localparam int unsigned ScoreW = 26;
  localparam int unsigned RankW  = 4;

  localparam int unsigned NW   = 24;
  localparam int unsigned AvgW = 28;
  localparam int unsigned TopW = 5;
  localparam int unsigned QtW  = 5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 28;

  localparam logic [CfgIdxW-1:0] CfgTotalDocs  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAvgLen     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTopCount   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgConj       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgQueryTerms = 3'd4;

  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 64;

  // Datapath widths of the scoring arithmetic.
  localparam int unsigned TaW   = 44;
  localparam int unsigned NumW  = 49;
  localparam int unsigned DenW  = 48;
  localparam int unsigned TfcW  = 18;
  localparam int unsigned LogW  = 21;
  localparam int unsigned IdfW  = 21;
  localparam int unsigned TermW = 23;
  localparam int unsigned LogVW = 26;
  localparam int unsigned ExpW  = 5;
  localparam int unsigned FracW = 16;

  // ln 2 in Q0.32.
  localparam logic [31:0] Ln2Q32 = 32'hB17217F8;

  localparam logic [ScoreW-1:0] ScoreMax = '1;

  typedef enum logic {
    KindPosting = 1'b0,
    KindEnd     = 1'b1
  } bts_kind_e;

  typedef enum logic {
    CmdOffer = 1'b0,
    CmdEmit  = 1'b1
  } bts_cmd_e;

  typedef enum logic [2:0] {
    ScIdle,
    ScPrep,
    ScLogNorm,
    ScLogSquare,
    ScIdf,
    ScTerm,
    ScAcc,
    ScCmd
  } bts_sc_state_e;

  typedef enum logic [2:0] {
    TkIdle,
    TkScan,
    TkRepl,
    TkEmitScan,
    TkEmitOut,
    TkEmpty
  } bts_tk_state_e;

  typedef struct packed {
    bts_kind_e         kind;
    logic              last;
    logic [DocW-1:0]   doc;
    logic [TfW-1:0]    tf;
    logic [DfW-1:0]    df;
    logic [DlW-1:0]    dl;
  } bts_item_t;

  typedef struct packed {
    logic              valid;
    bts_cmd_e          op;
    logic [DocW-1:0]   doc;
    logic [ScoreW-1:0] score;
  } bts_cmd_t;

  // True when entry a comes before entry b in the ranking.
  function automatic logic ranks_before(logic [ScoreW-1:0] sa, logic [DocW-1:0] da,
                                        logic [ScoreW-1:0] sb, logic [DocW-1:0] db);
    return (sa > sb) || ((sa == sb) && (da < db));
  endfunction

endpackage

[sv/bts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/bts_front.sv]
// Front end: accepts stream transactions, classifies them and queues them.
module bts_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bts_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  logic                          s_axis_tuser,
  input  logic [bts_pkg::NW-1:0]        total_docs_i,
  output bts_pkg::bts_item_t            item_o,
  output logic                          item_valid_o,
  input  logic                          item_ready_i
);

  bts_pkg::bts_item_t           q_mem_q [bts_pkg::QueueDepth];
  logic [bts_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [bts_pkg::QPtrW:0]      count_q;
  bts_pkg::bts_item_t           in_item;
  logic [bts_pkg::DfW-1:0]      df_raw;
  logic                         push, pop;

  assign df_raw = s_axis_tdata[70:47];

  // Document frequency is clipped to the collection size on the way in.
  always_comb begin
    in_item.kind = bts_pkg::bts_kind_e'(s_axis_tuser);
    in_item.last = s_axis_tlast;
    in_item.doc  = s_axis_tdata[30:0];
    in_item.tf   = s_axis_tdata[46:31];
    in_item.df   = (df_raw > total_docs_i) ? total_docs_i : df_raw;
    in_item.dl   = s_axis_tdata[90:71];
  end

  assign s_axis_tready = (count_q != (bts_pkg::QPtrW+1)'(bts_pkg::QueueDepth));
  assign item_valid_o  = (count_q != '0);
  assign item_o        = q_mem_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[sv/bts_score.sv]
// Back end scoring: iterative log2 and division, term score and per-document sum.
module bts_score (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bts_pkg::bts_item_t         item_i,
  input  logic                       item_valid_i,
  output logic                       item_ready_o,
  input  logic [bts_pkg::NW-1:0]     total_docs_i,
  input  logic [bts_pkg::AvgW-1:0]   avg_len_i,
  input  logic                       conj_i,
  input  logic [bts_pkg::QtW-1:0]    query_terms_i,
  output bts_pkg::bts_cmd_t          cmd_o,
  input  logic                       cmd_ready_i
);

  bts_pkg::bts_sc_state_e state_q, state_d;

  bts_pkg::bts_item_t            item_q;
  logic [bts_pkg::TaW-1:0]       ta_q;
  logic                          sel_q;
  logic [bts_pkg::ExpW-1:0]      e_q;
  logic [31:0]                   y_q;
  logic [bts_pkg::FracW-1:0]     frac_q;
  logic [3:0]                    cnt_q;
  logic [bts_pkg::LogW-1:0]      hi_q, lo_q;
  logic [bts_pkg::DenW-1:0]      rem_q, den_q;
  logic [1:0]                    num_lo_q;
  logic [bts_pkg::ExpW-1:0]      div_cnt_q;
  logic [bts_pkg::TfcW-1:0]      tfc_q;
  logic [bts_pkg::IdfW-1:0]      idf_q;
  logic [bts_pkg::TermW-1:0]     term_q;
  logic [bts_pkg::ScoreW-1:0]    sum_q;
  logic [4:0]                    pcount_q;
  bts_pkg::bts_cmd_e             cmd_op_q;
  logic [bts_pkg::DocW-1:0]      cmd_doc_q;
  logic [bts_pkg::ScoreW-1:0]    cmd_score_q;

  logic [bts_pkg::AvgW-1:0]      a_val;
  logic [bts_pkg::TaW-1:0]       ta_prod;
  logic [bts_pkg::NumW-1:0]      num;
  logic [bts_pkg::DenW-1:0]      den;
  logic [bts_pkg::LogVW-1:0]     log_v;
  logic [bts_pkg::ExpW-1:0]      msb;
  logic [31:0]                   y_init;
  logic [63:0]                   sq;
  logic                          sq_bit;
  logic [31:0]                   y_next;
  logic [bts_pkg::FracW-1:0]     frac_next;
  logic                          nb;
  logic [bts_pkg::DenW:0]        rem2, rem_sub;
  logic                          ge;
  logic [bts_pkg::LogW-1:0]      diff;
  logic [52:0]                   idf_prod;
  logic [38:0]                   term_prod;
  logic [bts_pkg::ScoreW:0]      sum_wide;
  logic [bts_pkg::ScoreW-1:0]    sum_sat;
  logic [4:0]                    pcount_inc;
  logic                          admit;
  logic                          div_start;

  assign a_val   = (avg_len_i == '0) ? bts_pkg::AvgW'(1) : avg_len_i;
  assign ta_prod = bts_pkg::TaW'(item_q.tf) * bts_pkg::TaW'(a_val);

  assign num = bts_pkg::NumW'({ta_q, 4'b0}) + bts_pkg::NumW'({ta_q, 2'b0});
  assign den = bts_pkg::DenW'({ta_q, 3'b0}) + bts_pkg::DenW'({a_val, 1'b0})
             + bts_pkg::DenW'(a_val) + bts_pkg::DenW'({item_q.dl, 11'b0})
             + bts_pkg::DenW'({item_q.dl, 8'b0});

  // Log operand: 2N+2 first, then 2df+1.
  assign log_v = sel_q ? (bts_pkg::LogVW'({item_q.df, 1'b0}) + bts_pkg::LogVW'(1))
                       : (bts_pkg::LogVW'({total_docs_i, 1'b0}) + bts_pkg::LogVW'(2));

  always_comb begin
    msb = '0;
    for (int i = 0; i < bts_pkg::LogVW; i++) begin
      if (log_v[i]) begin
        msb = bts_pkg::ExpW'(i);
      end
    end
  end

  assign y_init    = {6'b0, log_v} << (5'd31 - msb);
  assign sq        = {32'b0, y_q} * {32'b0, y_q};
  assign sq_bit    = sq[63];
  assign y_next    = sq_bit ? sq[63:32] : sq[62:31];
  assign frac_next = frac_q | ({15'b0, sq_bit} << cnt_q);

  // Restoring division step: two numerator bits feed in, then zeros.
  always_comb begin
    if (div_cnt_q == bts_pkg::ExpW'(bts_pkg::TfcW)) begin
      nb = num_lo_q[1];
    end else if (div_cnt_q == bts_pkg::ExpW'(bts_pkg::TfcW - 1)) begin
      nb = num_lo_q[0];
    end else begin
      nb = 1'b0;
    end
  end

  assign rem2    = {rem_q, nb};
  assign ge      = rem2 >= {1'b0, den_q};
  assign rem_sub = rem2 - {1'b0, den_q};

  assign diff      = (hi_q > lo_q) ? (hi_q - lo_q) : '0;
  assign idf_prod  = 53'(diff) * 53'(bts_pkg::Ln2Q32);
  assign term_prod = 39'(idf_q) * 39'(tfc_q);

  assign sum_wide   = {1'b0, sum_q} + (bts_pkg::ScoreW+1)'(term_q);
  assign sum_sat    = sum_wide[bts_pkg::ScoreW] ? bts_pkg::ScoreMax : sum_wide[bts_pkg::ScoreW-1:0];
  assign pcount_inc = (pcount_q == 5'd31) ? pcount_q : pcount_q + 5'd1;
  assign admit      = !conj_i || (pcount_inc >= query_terms_i);

  assign div_start    = (state_q == bts_pkg::ScLogNorm) && !sel_q;
  assign item_ready_o = (state_q == bts_pkg::ScIdle);

  always_comb begin
    cmd_o.valid = (state_q == bts_pkg::ScCmd);
    cmd_o.op    = cmd_op_q;
    cmd_o.doc   = cmd_doc_q;
    cmd_o.score = cmd_score_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bts_pkg::ScIdle: begin
        if (item_valid_i) begin
          state_d = (item_i.kind == bts_pkg::KindEnd) ? bts_pkg::ScCmd : bts_pkg::ScPrep;
        end
      end
      bts_pkg::ScPrep:      state_d = bts_pkg::ScLogNorm;
      bts_pkg::ScLogNorm:   state_d = bts_pkg::ScLogSquare;
      bts_pkg::ScLogSquare: begin
        if (cnt_q == '0) begin
          state_d = sel_q ? bts_pkg::ScIdf : bts_pkg::ScLogNorm;
        end
      end
      bts_pkg::ScIdf:  state_d = bts_pkg::ScTerm;
      bts_pkg::ScTerm: state_d = bts_pkg::ScAcc;
      bts_pkg::ScAcc: begin
        if (item_q.last && admit) begin
          state_d = bts_pkg::ScCmd;
        end else begin
          state_d = bts_pkg::ScIdle;
        end
      end
      bts_pkg::ScCmd: begin
        if (cmd_ready_i) begin
          state_d = bts_pkg::ScIdle;
        end
      end
      default: state_d = bts_pkg::ScIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bts_pkg::ScIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      bts_pkg::ScIdle: begin
        if (item_valid_i) begin
          item_q   <= item_i;
          cmd_op_q <= bts_pkg::CmdEmit;
        end
      end
      bts_pkg::ScPrep: ta_q <= ta_prod;
      bts_pkg::ScLogNorm: begin
        e_q    <= msb;
        y_q    <= y_init;
        frac_q <= '0;
      end
      bts_pkg::ScLogSquare: begin
        y_q    <= y_next;
        frac_q <= frac_next;
        if (cnt_q == '0) begin
          if (sel_q) begin
            lo_q <= {e_q, frac_next};
          end else begin
            hi_q <= {e_q, frac_next};
          end
        end
      end
      bts_pkg::ScIdf:  idf_q  <= idf_prod[52:32];
      bts_pkg::ScTerm: term_q <= term_prod[38:16];
      bts_pkg::ScAcc: begin
        cmd_op_q    <= bts_pkg::CmdOffer;
        cmd_doc_q   <= item_q.doc;
        cmd_score_q <= sum_sat;
      end
      default: ;
    endcase

    if (div_start) begin
      rem_q    <= bts_pkg::DenW'(num >> 2);
      den_q    <= den;
      num_lo_q <= num[1:0];
    end else if (div_cnt_q != '0) begin
      rem_q <= ge ? rem_sub[bts_pkg::DenW-1:0] : rem2[bts_pkg::DenW-1:0];
      tfc_q <= {tfc_q[bts_pkg::TfcW-2:0], ge};
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= 1'b0;
      cnt_q     <= '0;
      div_cnt_q <= '0;
      sum_q     <= '0;
      pcount_q  <= '0;
    end else begin
      case (state_q)
        bts_pkg::ScIdle: begin
          if (item_valid_i && (item_i.kind == bts_pkg::KindEnd)) begin
            sum_q    <= '0;
            pcount_q <= '0;
          end
        end
        bts_pkg::ScPrep:      sel_q <= 1'b0;
        bts_pkg::ScLogNorm:   cnt_q <= 4'd15;
        bts_pkg::ScLogSquare: begin
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == '0) begin
            sel_q <= 1'b1;
          end
        end
        bts_pkg::ScAcc: begin
          if (item_q.last) begin
            sum_q    <= '0;
            pcount_q <= '0;
          end else begin
            sum_q    <= sum_sat;
            pcount_q <= pcount_inc;
          end
        end
        default: ;
      endcase

      if (div_start) begin
        div_cnt_q <= bts_pkg::ExpW'(bts_pkg::TfcW);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/bts_topk.sv]
// Back end store: top-k entries in RAM, replacement scan and ranked emission.
module bts_topk #(
  parameter int unsigned MaxKeep = bts_pkg::MaxKeepDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bts_pkg::bts_cmd_t             cmd_i,
  output logic                          cmd_ready_o,
  input  logic [bts_pkg::TopW-1:0]      top_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bts_pkg::DocW-1:0]      out_doc_o,
  output logic [bts_pkg::ScoreW-1:0]    out_score_o,
  output logic [bts_pkg::RankW-1:0]     out_rank_o,
  output logic                          out_empty_o,
  output logic                          out_last_o
);

  localparam int unsigned AW = (MaxKeep > 1) ? $clog2(MaxKeep) : 1;
  localparam int unsigned FW = $clog2(MaxKeep + 1);
  localparam int unsigned CW = (FW > bts_pkg::TopW) ? FW : bts_pkg::TopW;
  localparam int unsigned EW = bts_pkg::DocW + bts_pkg::ScoreW;

  bts_pkg::bts_tk_state_e state_q, state_d;

  logic [FW-1:0]                fill_q, issue_q, r_q;
  logic                         pend_q, have_q;
  logic [AW-1:0]                pidx_q, bidx_q;
  logic [bts_pkg::DocW-1:0]     bdoc_q, odoc_q;
  logic [bts_pkg::ScoreW-1:0]   bscore_q, oscore_q;
  logic [MaxKeep-1:0]           emitted_q;

  logic                         we;
  logic [AW-1:0]                waddr;
  logic [EW-1:0]                wdata, rdata;
  logic [bts_pkg::DocW-1:0]     r_doc;
  logic [bts_pkg::ScoreW-1:0]   r_score;
  logic [CW-1:0]                tc, limit;
  logic                         has_room, rd_en, scan_done, take, slot_free, is_last;

  assign r_doc   = rdata[EW-1:bts_pkg::ScoreW];
  assign r_score = rdata[bts_pkg::ScoreW-1:0];

  assign tc    = CW'(top_count_i);
  assign limit = (tc == '0) ? CW'(1) : ((tc > CW'(MaxKeep)) ? CW'(MaxKeep) : tc);
  assign has_room = CW'(fill_q) < limit;

  assign rd_en     = ((state_q == bts_pkg::TkScan) || (state_q == bts_pkg::TkEmitScan))
                     && (issue_q < fill_q);
  assign scan_done = (issue_q == fill_q) && !pend_q;
  assign slot_free = !out_valid_o || out_ready_i;
  assign is_last   = ((r_q + FW'(1)) == fill_q);

  always_comb begin
    take = 1'b0;
    if (pend_q) begin
      if (state_q == bts_pkg::TkScan) begin
        take = !have_q || bts_pkg::ranks_before(bscore_q, bdoc_q, r_score, r_doc);
      end else if (state_q == bts_pkg::TkEmitScan) begin
        take = !emitted_q[pidx_q]
               && (!have_q || bts_pkg::ranks_before(r_score, r_doc, bscore_q, bdoc_q));
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = fill_q[AW-1:0];
    wdata = {cmd_i.doc, cmd_i.score};
    if ((state_q == bts_pkg::TkIdle) && cmd_i.valid && (cmd_i.op == bts_pkg::CmdOffer)
        && has_room) begin
      we = 1'b1;
    end else if ((state_q == bts_pkg::TkRepl) && (oscore_q > bscore_q)) begin
      we    = 1'b1;
      waddr = bidx_q;
      wdata = {odoc_q, oscore_q};
    end
  end

  bts_ram #(
    .Width (EW),
    .Depth (MaxKeep),
    .AddrW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign cmd_ready_o = (state_q == bts_pkg::TkIdle);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bts_pkg::TkIdle: begin
        if (cmd_i.valid) begin
          if (cmd_i.op == bts_pkg::CmdEmit) begin
            state_d = (fill_q == '0) ? bts_pkg::TkEmpty : bts_pkg::TkEmitScan;
          end else if (!has_room) begin
            state_d = bts_pkg::TkScan;
          end
        end
      end
      bts_pkg::TkScan: begin
        if (scan_done) begin
          state_d = bts_pkg::TkRepl;
        end
      end
      bts_pkg::TkRepl: state_d = bts_pkg::TkIdle;
      bts_pkg::TkEmitScan: begin
        if (scan_done) begin
          state_d = bts_pkg::TkEmitOut;
        end
      end
      bts_pkg::TkEmitOut: begin
        if (slot_free) begin
          state_d = is_last ? bts_pkg::TkIdle : bts_pkg::TkEmitScan;
        end
      end
      bts_pkg::TkEmpty: begin
        if (slot_free) begin
          state_d = bts_pkg::TkIdle;
        end
      end
      default: state_d = bts_pkg::TkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bts_pkg::TkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Best/worst candidate and pending offer payload.
  always_ff @(posedge clk_i) begin
    if ((state_q == bts_pkg::TkIdle) && cmd_i.valid) begin
      odoc_q   <= cmd_i.doc;
      oscore_q <= cmd_i.score;
    end
    if (take) begin
      bdoc_q   <= r_doc;
      bscore_q <= r_score;
      bidx_q   <= pidx_q;
    end
    pidx_q <= issue_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (((state_q == bts_pkg::TkEmitOut) || (state_q == bts_pkg::TkEmpty)) && slot_free) begin
      out_doc_o   <= (state_q == bts_pkg::TkEmpty) ? '0 : bdoc_q;
      out_score_o <= (state_q == bts_pkg::TkEmpty) ? '0 : bscore_q;
      out_rank_o  <= (state_q == bts_pkg::TkEmpty) ? '0 : bts_pkg::RankW'(r_q);
      out_empty_o <= (state_q == bts_pkg::TkEmpty);
      out_last_o  <= (state_q == bts_pkg::TkEmpty) || is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      issue_q     <= '0;
      r_q         <= '0;
      pend_q      <= 1'b0;
      have_q      <= 1'b0;
      emitted_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      pend_q <= rd_en;
      if (rd_en) begin
        issue_q <= issue_q + FW'(1);
      end
      if (take) begin
        have_q <= 1'b1;
      end

      // A new result is loaded when the output slot is free in the emit or empty
      // state; otherwise an accepted result empties it.
      if (((state_q == bts_pkg::TkEmitOut) || (state_q == bts_pkg::TkEmpty)) && slot_free) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      case (state_q)
        bts_pkg::TkIdle: begin
          issue_q <= '0;
          have_q  <= 1'b0;
          r_q     <= '0;
          if (we) begin
            fill_q <= fill_q + FW'(1);
          end
        end
        bts_pkg::TkEmitOut: begin
          if (slot_free) begin
            issue_q <= '0;
            have_q  <= 1'b0;
            r_q     <= r_q + FW'(1);
            if (is_last) begin
              fill_q    <= '0;
              emitted_q <= '0;
            end else begin
              emitted_q[bidx_q] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[sv/bts_top_placeholder_unused.sv]
// Configuration register bank of the BM25 top-k scorer.
module bts_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [bts_pkg::CfgIdxW-1:0]   idx_i,
  input  logic [bts_pkg::CfgDataW-1:0]  data_i,
  output logic [bts_pkg::NW-1:0]        total_docs_o,
  output logic [bts_pkg::AvgW-1:0]      avg_len_o,
  output logic [bts_pkg::TopW-1:0]      top_count_o,
  output logic                          conj_o,
  output logic [bts_pkg::QtW-1:0]       query_terms_o
);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_docs_o  <= '0;
      avg_len_o     <= bts_pkg::AvgW'(256);
      top_count_o   <= bts_pkg::TopW'(10);
      conj_o        <= 1'b0;
      query_terms_o <= bts_pkg::QtW'(1);
    end else if (we_i) begin
      case (idx_i)
        bts_pkg::CfgTotalDocs:  total_docs_o  <= data_i[bts_pkg::NW-1:0];
        bts_pkg::CfgAvgLen:     avg_len_o     <= data_i[bts_pkg::AvgW-1:0];
        bts_pkg::CfgTopCount:   top_count_o   <= data_i[bts_pkg::TopW-1:0];
        bts_pkg::CfgConj:       conj_o        <= data_i[0];
        bts_pkg::CfgQueryTerms: query_terms_o <= data_i[bts_pkg::QtW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/bm25_topk_scorer.sv]
// Top level of the BM25 top-k scorer: front queue, scoring back end and top-k store.
//
// Postings, already merged by document, enter on the slave stream and each adds a
// BM25 term score (k1 = 1.5, b = 0.75, unsigned Q10.16) to the running sum of its
// document; the posting flagged by tlast closes the document and offers it to the
// top-k store, in conjunctive mode only if the document has enough query terms. An
// end-of-query transaction (tuser high) drains the store in ranked order on the
// master stream and clears it. Two log2 evaluations by repeated squaring on one
// shared 32x32 multiplier occupy the scoring engine for each posting, and the
// restoring divider for the term frequency factor runs under them. Offering a
// document is a single write while the store has room, otherwise a scan of the held
// entries through the store's read port, overlapped with the next posting. Emitting
// results takes one RAM scan per result. A four-deep queue sits between the input
// stream and the scoring engine, so input transactions are still taken, until it
// fills, while results wait on the master side.
module bm25_topk_scorer #(
  parameter int unsigned MaxKeep = bts_pkg::MaxKeepDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [bts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bts_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata fields from bit 0: doc_id[31], term_freq[16], doc_freq[24], doc_length[20].
  input  logic [bts_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,   // last_of_doc
  input  logic                          s_axis_tuser,   // mode
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata fields from bit 0: result_doc[31], result_score[26], rank[4].
  output logic [bts_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,   // last
  output logic                          m_axis_tuser    // empty_res
);

  logic [bts_pkg::NW-1:0]      total_docs;
  logic [bts_pkg::AvgW-1:0]    avg_len;
  logic [bts_pkg::TopW-1:0]    top_count;
  logic                        conj;
  logic [bts_pkg::QtW-1:0]     query_terms;

  bts_pkg::bts_item_t          item;
  logic                        item_valid, item_ready;
  bts_pkg::bts_cmd_t           cmd;
  logic                        cmd_ready;

  logic [bts_pkg::DocW-1:0]    out_doc;
  logic [bts_pkg::ScoreW-1:0]  out_score;
  logic [bts_pkg::RankW-1:0]   out_rank;

  bts_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .we_i          (cfg_we_i),
    .idx_i         (cfg_idx_i),
    .data_i        (cfg_data_i),
    .total_docs_o  (total_docs),
    .avg_len_o     (avg_len),
    .top_count_o   (top_count),
    .conj_o        (conj),
    .query_terms_o (query_terms)
  );

  bts_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .total_docs_i  (total_docs),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready)
  );

  bts_score u_score (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .total_docs_i  (total_docs),
    .avg_len_i     (avg_len),
    .conj_i        (conj),
    .query_terms_i (query_terms),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  bts_topk #(
    .MaxKeep (MaxKeep)
  ) u_topk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .top_count_i (top_count),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_doc_o   (out_doc),
    .out_score_o (out_score),
    .out_rank_o  (out_rank),
    .out_empty_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_rank, out_score, out_doc};

  // The empty result is a single, all-zero, final transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("empty result is not a lone zero transaction");

  // A command waiting on the store keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.valid && !cmd_ready) |=> (cmd.valid && $stable(cmd.op) && $stable(cmd.doc)
                                   && $stable(cmd.score)))
    else $error("store command changed while stalled");

  // A new run of results always starts at rank zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast)
      |=> (!m_axis_tvalid || (m_axis_tdata[60:57] == '0)))
    else $error("result run did not start at rank zero");

endmodule
